[rtl/pmsbm_pkg.sv]
// ----------------------------------------------------------------------------
// pmsbm_pkg
// Shared widths, register codes and arithmetic step functions for the
// per-pixel mean / standard-deviation background model.
// ----------------------------------------------------------------------------
package pmsbm_pkg;

  localparam int PIXELS     = 65536;
  localparam int ADDR_W     = $clog2(PIXELS);
  localparam int MAX_FRAMES = 256;
  localparam int FC_W       = $clog2(MAX_FRAMES + 1);
  localparam int NCH        = 3;

  localparam int IDX_W   = 16;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int SQS_W   = 24;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = 2;

  // variance numerator Q*N - S*S
  localparam int VAR_W    = SQS_W + FC_W;
  // radicand var << 16, padded to an even width
  localparam int RAD_W    = 2 * ((VAR_W + 16 + 1) / 2);
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int SQ_STEPS = ROOT_W;
  localparam int DIV_W    = ROOT_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int STD_W    = DIV_W + 1;
  localparam int PROD_W   = SCALE_W + STD_W + 1;
  localparam int CMP_W    = PROD_W + 2;

  localparam logic [STD_W-1:0] STD_BIAS = STD_W'(26);

  localparam int FIFO_DEPTH = 64;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = FIFO_AW + 1;

  localparam logic signed [SCALE_W-1:0] HIGH_RESET = 16'sd5376;
  localparam logic signed [SCALE_W-1:0] LOW_RESET  = 16'sd512;

  typedef enum logic [CFG_W-1:0] {
    REG_MODE = 2'd0,
    REG_HIGH = 2'd1,
    REG_LOW  = 2'd2
  } reg_idx_t;

  typedef logic [NCH-1:0][SUM_W-1:0] sum_word_t;
  typedef logic [NCH-1:0][SQS_W-1:0] sqs_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             nm;
    logic [FC_W-1:0]  n;
  } tag_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    sqrt_t            sq;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] x;
  } sq_lane_t;

  typedef struct packed {
    logic [DIV_W-1:0] quo;
    logic [FC_W-1:0]  rem;
  } div_t;

  typedef struct packed {
    div_t             sd;
    div_t             md;
    logic [PIX_W-1:0] x;
  } div_lane_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fg;
    logic             nm;
  } res_t;

  // one result bit of the integer square root
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] trial;
    sqrt_t            o;
    r     = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (r >= trial) begin
      o.rem  = REM_W'(r - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of restoring division; dividend shifts out as quotient shifts in
  function automatic div_t div_step(input div_t d, input logic [FC_W-1:0] n);
    logic [FC_W:0] r;
    div_t          o;
    r = {d.rem, d.quo[DIV_W-1]};
    if (r >= {1'b0, n}) begin
      o.rem = FC_W'(r - {1'b0, n});
      o.quo = {d.quo[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = r[FC_W-1:0];
      o.quo = {d.quo[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/pixel_mean_stddev_background_model.sv]
// ----------------------------------------------------------------------------
// pixel_mean_stddev_background_model
// Per-pixel running sums in block RAM; training updates the sums, detect mode
// classifies each pixel per channel against mean - low*std .. mean + high*std.
// ----------------------------------------------------------------------------
// channel   signals                                       direction
// cfg       cfg_write, cfg_index, cfg_data                in
// pixel     in_valid/in_ready, pixel_index, chan_*,       in
//           frame_end
// result    out_valid/out_ready, out_index, foreground,   out
//           no_model
//
// One pixel per clock while in_ready is high. Training words do a
// read-modify-write of the sum RAMs with one-deep forwarding; detect words
// run a pipeline (25-step square root, then 25-step division by the frame
// count) into a 64-word output FIFO. After rst a clearing pass zeroes both
// RAMs, in_ready low; then input stalls only at 64 results in flight or queued.
// ----------------------------------------------------------------------------
module pixel_mean_stddev_background_model (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pmsbm_pkg::CFG_W-1:0]         cfg_index,
  input  logic [pmsbm_pkg::SCALE_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pmsbm_pkg::IDX_W-1:0]         pixel_index,
  input  logic [pmsbm_pkg::PIX_W-1:0]         chan_zero,
  input  logic [pmsbm_pkg::PIX_W-1:0]         chan_one,
  input  logic [pmsbm_pkg::PIX_W-1:0]         chan_two,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pmsbm_pkg::IDX_W-1:0]         out_index,
  output logic                                foreground,
  output logic                                no_model
);
  import pmsbm_pkg::*;

  // configuration
  logic                      mode;
  logic signed [SCALE_W-1:0] high_scale;
  logic signed [SCALE_W-1:0] low_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      high_scale <= HIGH_RESET;
      low_scale  <= LOW_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: mode       <= cfg_data[0];
        REG_HIGH: high_scale <= cfg_data;
        REG_LOW:  low_scale  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // clearing pass
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(PIXELS - 1)) clr_busy <= 1'b0;
    end
  end

  // handshake and credit count
  logic [OCC_W-1:0] occupied;
  logic             in_acc;
  logic             out_acc;

  assign in_ready = !clr_busy && (occupied < OCC_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else begin
      occupied <= occupied + OCC_W'(in_acc && mode) - OCC_W'(out_acc);
    end
  end

  // sum memories
  sum_word_t mem_sum [PIXELS];
  sqs_word_t mem_sqs [PIXELS];
  sum_word_t rd_sum;
  sqs_word_t rd_sqs;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  sum_word_t         wr_sum;
  sqs_word_t         wr_sqs;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_sum[mem_addr] <= wr_sum;
      mem_sqs[mem_addr] <= wr_sqs;
    end
  end

  always_ff @(posedge clk) begin
    rd_sum <= mem_sum[pixel_index[ADDR_W-1:0]];
    rd_sqs <= mem_sqs[pixel_index[ADDR_W-1:0]];
  end

  // stage 1: read data back, modify, write
  logic             s1_vld;
  logic             s1_det;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_fe;
  logic [NCH-1:0][PIX_W-1:0] s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_acc;
    end
    s1_det <= mode;
    s1_idx <= pixel_index;
    s1_fe  <= frame_end;
    s1_x   <= {chan_two, chan_one, chan_zero};
  end

  logic [FC_W-1:0]   frame_count;
  logic              wl_vld;
  logic [ADDR_W-1:0] wl_slot;
  sum_word_t         wl_sum;
  sqs_word_t         wl_sqs;
  sum_word_t         cur_sum;
  sqs_word_t         cur_sqs;
  sum_word_t         new_sum;
  sqs_word_t         new_sqs;
  logic              train_wr;

  // previous word's write lands on the edge this word was read
  always_comb begin
    if (wl_vld && (wl_slot == s1_idx[ADDR_W-1:0])) begin
      cur_sum = wl_sum;
      cur_sqs = wl_sqs;
    end else begin
      cur_sum = rd_sum;
      cur_sqs = rd_sqs;
    end
    for (int c = 0; c < NCH; c++) begin
      new_sum[c] = cur_sum[c] + SUM_W'(s1_x[c]);
      new_sqs[c] = cur_sqs[c] + SQS_W'(16'(s1_x[c]) * 16'(s1_x[c]));
    end
  end

  assign train_wr = s1_vld && !s1_det && (frame_count < FC_W'(MAX_FRAMES));
  assign mem_we   = clr_busy || train_wr;
  assign mem_addr = clr_busy ? clr_addr : s1_idx[ADDR_W-1:0];
  assign wr_sum   = clr_busy ? '0 : new_sum;
  assign wr_sqs   = clr_busy ? '0 : new_sqs;

  always_ff @(posedge clk) begin
    if (rst) begin
      wl_vld      <= 1'b0;
      frame_count <= '0;
    end else begin
      wl_vld <= train_wr;
      if (train_wr && s1_fe) frame_count <= frame_count + 1'b1;
    end
    wl_slot <= s1_idx[ADDR_W-1:0];
    wl_sum  <= new_sum;
    wl_sqs  <= new_sqs;
  end

  // p1: operands
  logic                      p1_vld;
  tag_t                      p1_tag;
  logic [NCH-1:0][SUM_W-1:0] p1_s;
  logic [NCH-1:0][SQS_W-1:0] p1_q;
  logic [NCH-1:0][PIX_W-1:0] p1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= s1_vld && s1_det;
    end
    p1_tag <= '{idx: s1_idx, nm: (frame_count == '0), n: frame_count};
    p1_s   <= cur_sum;
    p1_q   <= cur_sqs;
    p1_x   <= s1_x;
  end

  // p2: products
  logic                         p2_vld;
  tag_t                         p2_tag;
  logic [NCH-1:0][VAR_W-1:0]    p2_qn;
  logic [NCH-1:0][2*SUM_W-1:0]  p2_ss;
  logic [NCH-1:0][SUM_W-1:0]    p2_s;
  logic [NCH-1:0][PIX_W-1:0]    p2_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_tag <= p1_tag;
    for (int c = 0; c < NCH; c++) begin
      p2_qn[c] <= VAR_W'(p1_q[c] * p1_tag.n);
      p2_ss[c] <= p1_s[c] * p1_s[c];
    end
    p2_s <= p1_s;
    p2_x <= p1_x;
  end

  // square root pipeline
  logic [NCH-1:0][VAR_W-1:0] var_num;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (p2_qn[c] > VAR_W'(p2_ss[c])) begin
        var_num[c] = p2_qn[c] - VAR_W'(p2_ss[c]);
      end else begin
        var_num[c] = '0;
      end
    end
  end

  logic     sq_vld [SQ_STEPS+1];
  tag_t     sq_tag [SQ_STEPS+1];
  sq_lane_t sq_ln  [SQ_STEPS+1][NCH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) sq_vld[k] <= 1'b0;
    end else begin
      sq_vld[0] <= p2_vld;
      for (int k = 0; k < SQ_STEPS; k++) sq_vld[k+1] <= sq_vld[k];
    end
    sq_tag[0] <= p2_tag;
    for (int c = 0; c < NCH; c++) begin
      sq_ln[0][c].sq.rad  <= RAD_W'({var_num[c], 16'h0000});
      sq_ln[0][c].sq.rem  <= '0;
      sq_ln[0][c].sq.root <= '0;
      sq_ln[0][c].sum     <= p2_s[c];
      sq_ln[0][c].x       <= p2_x[c];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_tag[k+1] <= sq_tag[k];
      for (int c = 0; c < NCH; c++) begin
        sq_ln[k+1][c].sq  <= sqrt_step(sq_ln[k][c].sq);
        sq_ln[k+1][c].sum <= sq_ln[k][c].sum;
        sq_ln[k+1][c].x   <= sq_ln[k][c].x;
      end
    end
  end

  // division by frame count: std root and scaled mean side by side
  logic      dv_vld [DIV_STEPS+1];
  tag_t      dv_tag [DIV_STEPS+1];
  div_lane_t dv_ln  [DIV_STEPS+1][NCH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_vld[k] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[SQ_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) dv_vld[k+1] <= dv_vld[k];
    end
    dv_tag[0] <= sq_tag[SQ_STEPS];
    for (int c = 0; c < NCH; c++) begin
      dv_ln[0][c].sd.quo <= DIV_W'(sq_ln[SQ_STEPS][c].sq.root);
      dv_ln[0][c].sd.rem <= '0;
      dv_ln[0][c].md.quo <= DIV_W'({sq_ln[SQ_STEPS][c].sum, 8'h00});
      dv_ln[0][c].md.rem <= '0;
      dv_ln[0][c].x      <= sq_ln[SQ_STEPS][c].x;
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_tag[k+1] <= dv_tag[k];
      for (int c = 0; c < NCH; c++) begin
        dv_ln[k+1][c].sd <= div_step(dv_ln[k][c].sd, dv_tag[k].n);
        dv_ln[k+1][c].md <= div_step(dv_ln[k][c].md, dv_tag[k].n);
        dv_ln[k+1][c].x  <= dv_ln[k][c].x;
      end
    end
  end

  // p4: mean and std in Q8.8
  logic                      p4_vld;
  tag_t                      p4_tag;
  logic [NCH-1:0][DIV_W-1:0] p4_mean;
  logic [NCH-1:0][STD_W-1:0] p4_std;
  logic [NCH-1:0][PIX_W-1:0] p4_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else begin
      p4_vld <= dv_vld[DIV_STEPS];
    end
    p4_tag <= dv_tag[DIV_STEPS];
    for (int c = 0; c < NCH; c++) begin
      p4_mean[c] <= dv_ln[DIV_STEPS][c].md.quo;
      p4_std[c]  <= STD_W'(dv_ln[DIV_STEPS][c].sd.quo) + STD_BIAS;
      p4_x[c]    <= dv_ln[DIV_STEPS][c].x;
    end
  end

  // p5: scale * std
  logic                       p5_vld;
  tag_t                       p5_tag;
  logic signed [PROD_W-1:0]   p5_plo [NCH];
  logic signed [PROD_W-1:0]   p5_phi [NCH];
  logic [NCH-1:0][DIV_W-1:0]  p5_mean;
  logic [NCH-1:0][PIX_W-1:0]  p5_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_vld <= 1'b0;
    end else begin
      p5_vld <= p4_vld;
    end
    p5_tag <= p4_tag;
    for (int c = 0; c < NCH; c++) begin
      p5_plo[c] <= PROD_W'(low_scale * $signed({1'b0, p4_std[c]}));
      p5_phi[c] <= PROD_W'(high_scale * $signed({1'b0, p4_std[c]}));
    end
    p5_mean <= p4_mean;
    p5_x    <= p4_x;
  end

  // p6: band edges in Q16.16
  logic                      p6_vld;
  tag_t                      p6_tag;
  logic signed [CMP_W-1:0]   p6_lo [NCH];
  logic signed [CMP_W-1:0]   p6_hi [NCH];
  logic [NCH-1:0][PIX_W-1:0] p6_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_vld <= 1'b0;
    end else begin
      p6_vld <= p5_vld;
    end
    p6_tag <= p5_tag;
    for (int c = 0; c < NCH; c++) begin
      p6_lo[c] <= $signed(CMP_W'({p5_mean[c], 8'h00})) - CMP_W'(p5_plo[c]);
      p6_hi[c] <= $signed(CMP_W'({p5_mean[c], 8'h00})) + CMP_W'(p5_phi[c]);
    end
    p6_x <= p5_x;
  end

  // compare and classify
  logic           res_vld;
  res_t           res;
  logic [NCH-1:0] outside;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      outside[c] = !(($signed(CMP_W'({p6_x[c], 16'h0000})) >= p6_lo[c]) &&
                     ($signed(CMP_W'({p6_x[c], 16'h0000})) <= p6_hi[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= p6_vld;
    end
    res.idx <= p6_tag.idx;
    res.nm  <= p6_tag.nm;
    res.fg  <= !p6_tag.nm && (|outside);
  end

  // result FIFO; its read register is the output register
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [OCC_W-1:0]   fifo_cnt;
  logic               rd_en;

  assign rd_en = (fifo_cnt != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (res_vld) fifo_mem[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rd_en) {out_index, foreground, no_model} <= fifo_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fifo_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_vld) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      fifo_cnt <= fifo_cnt + OCC_W'(res_vld) - OCC_W'(rd_en);
      if (rd_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= OCC_W'(FIFO_DEPTH))
    else $error("credit count above FIFO depth");

  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> (fifo_cnt < OCC_W'(FIFO_DEPTH)))
    else $error("result FIFO overflow");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FC_W'(MAX_FRAMES))
    else $error("frame count past saturation");
`endif

endmodule

[verif/pixel_mean_stddev_background_model_checker.sv]
// ----------------------------------------------------------------------------
// pixel_mean_stddev_background_model_checker
// Watches the config, pixel and result channels, keeps its own per-pixel
// sums and frame count, predicts each classification and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_mean_stddev_background_model_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pmsbm_pkg::CFG_W-1:0]   cfg_index,
  input  logic [pmsbm_pkg::SCALE_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pmsbm_pkg::IDX_W-1:0]   pixel_index,
  input  logic [pmsbm_pkg::PIX_W-1:0]   chan_zero,
  input  logic [pmsbm_pkg::PIX_W-1:0]   chan_one,
  input  logic [pmsbm_pkg::PIX_W-1:0]   chan_two,
  input  logic                          frame_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pmsbm_pkg::IDX_W-1:0]   out_index,
  input  logic                          foreground,
  input  logic                          no_model,
  output int                            fail_count,
  output int                            pending
);
  import pmsbm_pkg::*;

  // key = slot * 4 + channel; untouched slots read as zero
  longint unsigned sum_tab [int];
  longint unsigned sqs_tab [int];
  int unsigned     trained_frames;
  logic            detect_mode;
  longint          high_mult;
  longint          low_mult;
  res_t            class_queue [$];

  assign pending = class_queue.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic bit in_band(longint unsigned x, longint unsigned s,
                                 longint unsigned q, longint unsigned n);
    longint unsigned mean_q;
    longint unsigned var_num;
    longint unsigned std_q;
    longint          xv;
    longint          centre;
    longint          lo;
    longint          hi;
    mean_q  = (s * 256) / n;
    var_num = (q * n > s * s) ? q * n - s * s : 0;
    std_q   = int_sqrt((var_num * 65536) / (n * n)) + 26;
    xv      = longint'(x * 65536);
    centre  = longint'(mean_q * 256);
    lo      = centre - low_mult * longint'(std_q);
    hi      = centre + high_mult * longint'(std_q);
    return (xv >= lo) && (xv <= hi);
  endfunction

  function automatic longint unsigned tab_get(ref longint unsigned tab [int], input int key);
    return tab.exists(key) ? tab[key] : 0;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [PIX_W-1:0] px [3];
    res_t             want;
    int               key;
    if (rst) begin
      sum_tab.delete();
      sqs_tab.delete();
      class_queue.delete();
      trained_frames = 0;
      detect_mode    = 1'b0;
      high_mult      = 5376;
      low_mult       = 512;
      fail_count     = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE: detect_mode = cfg_data[0];
          REG_HIGH: high_mult   = longint'($signed(cfg_data));
          REG_LOW:  low_mult    = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        px[0] = chan_zero;
        px[1] = chan_one;
        px[2] = chan_two;
        if (!detect_mode) begin
          if (trained_frames < MAX_FRAMES) begin
            for (int c = 0; c < 3; c++) begin
              key = int'(pixel_index) * 4 + c;
              sum_tab[key] = tab_get(sum_tab, key) + px[c];
              sqs_tab[key] = tab_get(sqs_tab, key) + px[c] * px[c];
            end
            if (frame_end) trained_frames++;
          end
        end else begin
          want.idx = pixel_index;
          want.nm  = (trained_frames == 0);
          want.fg  = 1'b0;
          if (!want.nm) begin
            for (int c = 0; c < 3; c++) begin
              key = int'(pixel_index) * 4 + c;
              if (!in_band(px[c], tab_get(sum_tab, key), tab_get(sqs_tab, key),
                           trained_frames))
                want.fg = 1'b1;
            end
          end
          class_queue.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (class_queue.size() == 0) begin
          report("unexpected word, index", out_index, -1);
        end else begin
          want = class_queue.pop_front();
          if (out_index !== want.idx)  report("out_index", out_index, want.idx);
          if (foreground !== want.fg)  report("foreground", foreground, want.fg);
          if (no_model !== want.nm)    report("no_model", no_model, want.nm);
        end
      end
    end
  end

endmodule

[verif/tb_pixel_mean_stddev_background_model.sv]
// ----------------------------------------------------------------------------
// tb_pixel_mean_stddev_background_model
// Trains the model with short frames over a pool of pixel locations, then
// classifies pixels under several threshold settings, including no-model,
// saturated training and inverted bands, with bursty input and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pixel_mean_stddev_background_model;
  import pmsbm_pkg::*;

  localparam int FRAME_PIX = 4;
  localparam int POOL      = 8;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [CFG_W-1:0]    cfg_index;
  logic [SCALE_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [IDX_W-1:0]    pixel_index;
  logic [PIX_W-1:0]    chan_zero, chan_one, chan_two;
  logic                frame_end;
  logic                out_valid;
  logic                out_ready;
  logic [IDX_W-1:0]    out_index;
  logic                foreground;
  logic                no_model;
  int                  fail_count;
  int                  pending;

  int                  burst_left;
  int                  run_left;
  int                  stall_left;
  logic [IDX_W-1:0]    pool_base [POOL];
  int                  centre [POOL][3];

  always #5 clk = ~clk;

  pixel_mean_stddev_background_model u_dut (.*);

  pixel_mean_stddev_background_model_checker u_checker (.*);

  // result side stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready = 1'b1;
      run_left--;
    end else begin
      run_left   = $urandom_range(0, 30);
      stall_left = $urandom_range(0, 8) * (($urandom % 3 == 0) ? 4 : 1);
    end
  end

  task automatic pace();
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic send_pixel(input logic [IDX_W-1:0] idx, input int c0, input int c1,
                            input int c2, input logic fe);
    pace();
    pixel_index = idx;
    chan_zero   = c0[7:0];
    chan_one    = c1[7:0];
    chan_two    = c2[7:0];
    frame_end   = fe;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // training words give no result, so allow the pipeline to drain as well
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [SCALE_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic int near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, spread);
    return (v > 255) ? 255 : v;
  endfunction

  task automatic train_frames(input int count);
    int p;
    int k;
    for (int f = 0; f < count; f++) begin
      p = $urandom_range(0, POOL - 1);
      for (k = 0; k < FRAME_PIX; k++)
        send_pixel(pool_base[p] + k[IDX_W-1:0], near(centre[p][0], 20),
                   near(centre[p][1], 20), near(centre[p][2], 20),
                   k == FRAME_PIX - 1);
    end
  endtask

  task automatic detect_round(input int count);
    int          p;
    int          c [3];
    logic [15:0] idx;
    for (int i = 0; i < count; i++) begin
      p   = $urandom_range(0, POOL - 1);
      idx = ($urandom % 5 == 0) ? 16'($urandom) : pool_base[p] + 16'($urandom_range(0, 3));
      for (int j = 0; j < 3; j++) begin
        case ($urandom % 4)
          0:       c[j] = ($urandom % 2) ? 255 : 0;
          1:       c[j] = $urandom_range(0, 255);
          default: c[j] = near(centre[p][j], 30);
        endcase
      end
      send_pixel(idx, c[0], c[1], c[2], 1'($urandom % 2));
    end
  endtask

  initial begin
    int frames_sent;
    int round;
    int n;
    rst = 1'b1; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; pixel_index = '0; chan_zero = '0; chan_one = '0; chan_two = '0;
    frame_end = 1'b0; out_ready = 1'b1; burst_left = 0; run_left = 0; stall_left = 0;
    pool_base[0] = 16'd0;
    pool_base[1] = 16'd65532;
    for (int i = 2; i < POOL; i++) pool_base[i] = 16'($urandom) & 16'hFFFC;
    for (int i = 0; i < POOL; i++)
      for (int j = 0; j < 3; j++) centre[i][j] = $urandom_range(0, 235);
    centre[0][0] = 0;
    centre[1][1] = 235;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // untrained model: every word flags no_model
    write_reg(REG_MODE, 16'd1);
    write_reg(reg_idx_t'(3), 16'hFFFF);
    send_pixel(16'd0, 0, 0, 0, 1'b0);
    send_pixel(16'hFFFF, 255, 255, 255, 1'b1);
    send_pixel(16'hAAAA, 255, 0, 255, 1'b0);
    send_pixel(16'h5555, 0, 255, 0, 1'b1);
    wait_idle();

    frames_sent = 0;
    round = 0;
    while (frames_sent < 300) begin
      write_reg(REG_MODE, 16'd0);
      n = (round == 0) ? 1 : $urandom_range(5, 40);
      train_frames(n);
      frames_sent += n;
      wait_idle();
      write_reg(REG_MODE, 16'd1);
      case (round % 6)
        0: begin write_reg(REG_HIGH, 16'd5376);  write_reg(REG_LOW, 16'd512);   end
        1: begin write_reg(REG_HIGH, 16'h7FFF);  write_reg(REG_LOW, 16'h7FFF);  end
        2: begin write_reg(REG_HIGH, 16'h8000);  write_reg(REG_LOW, 16'h8000);  end
        3: begin write_reg(REG_HIGH, 16'd0);     write_reg(REG_LOW, 16'd0);     end
        4: begin write_reg(REG_HIGH, 16'($urandom)); write_reg(REG_LOW, 16'($urandom)); end
        default: begin write_reg(REG_HIGH, 16'd256); write_reg(REG_LOW, 16'd256); end
      endcase
      detect_round($urandom_range(30, 60));
      wait_idle();
      round++;
    end

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_mean_stddev_background_model test passed");
    end else begin
      $display("pixel_mean_stddev_background_model test failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("pixel_mean_stddev_background_model test failed");
    $finish;
  end

endmodule

[pixel_mean_stddev_background_model.f]
rtl/pmsbm_pkg.sv
rtl/pixel_mean_stddev_background_model.sv
verif/pixel_mean_stddev_background_model_checker.sv
verif/tb_pixel_mean_stddev_background_model.sv
